// ===== sv/fts_pkg.sv =====
package fts_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_CROSS,
    ST_SQINIT,
    ST_SQUARE,
    ST_SUM,
    ST_NINIT,
    ST_NORM,
    ST_EMIT
  } fts_state_e;

  // Last index of the product sequence and of the output beats
  localparam logic [2:0] PROD_LAST  = 3'd5;
  localparam logic [2:0] BEAT_LAST  = 3'd5;
  // First beat of the back face
  localparam logic [2:0] BACK_FIRST = 3'd3;

  // Beat order within a triangle
  localparam logic [2:0] BEAT_F_ORIGIN = 3'd0;
  localparam logic [2:0] BEAT_F_PRIOR  = 3'd1;
  localparam logic [2:0] BEAT_F_CUR    = 3'd2;
  localparam logic [2:0] BEAT_B_PRIOR  = 3'd3;
  localparam logic [2:0] BEAT_B_ORIGIN = 3'd4;
  localparam logic [2:0] BEAT_B_CUR    = 3'd5;

  localparam logic [1:0] SEEN_NONE   = 2'd0;
  localparam logic [1:0] SEEN_ORIGIN = 2'd1;
  localparam logic [1:0] SEEN_TWO    = 2'd2;

  localparam logic [2:0] COLOR_DEFAULT = 3'd7;

  // Commands from sequencer to datapath
  typedef struct packed {
    logic       in_ready;
    logic       diff_en;
    logic       prod_en;
    logic [2:0] idx;
    logic       cross_en;
    logic       sq_init;
    logic       sq_step;
    logic       sum_en;
    logic       norm_init;
    logic       norm_step;
    logic       out_load;
  } fts_cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic tri_start;
    logic sq_done;
    logic norm_done;
    logic out_free;
  } fts_stat_t;

  // Palette lookup, RGB packed red high
  function automatic logic [23:0] palette_rgb(logic [2:0] idx);
    logic [23:0] rgb;
    case (idx)
      3'd0:    rgb = {8'd32,  8'd32,  8'd32};
      3'd1:    rgb = {8'd24,  8'd24,  8'd182};
      3'd2:    rgb = {8'd32,  8'd186, 8'd32};
      3'd3:    rgb = {8'd65,  8'd178, 8'd178};
      3'd4:    rgb = {8'd207, 8'd24,  8'd24};
      3'd5:    rgb = {8'd170, 8'd56,  8'd170};
      3'd6:    rgb = {8'd195, 8'd199, 8'd36};
      default: rgb = {8'd170, 8'd170, 8'd170};
    endcase
    return rgb;
  endfunction

endpackage

// ===== sv/fts_vtx_if.sv =====
interface fts_vtx_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         starts_polygon;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic [7:0]                   color_index;

  modport source (
    output valid, starts_polygon, vertex_x, vertex_y, vertex_z, color_index,
    input  ready
  );
  modport sink (
    input  valid, starts_polygon, vertex_x, vertex_y, vertex_z, color_index,
    output ready
  );
endinterface

// ===== sv/fts_tri_if.sv =====
interface fts_tri_if #(
  parameter int COORD_BITS = 16,
  parameter int NORM_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic signed [NORM_BITS-1:0]  norm_x;
  logic signed [NORM_BITS-1:0]  norm_y;
  logic signed [NORM_BITS-1:0]  norm_z;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic                         last_of_triangle;

  modport source (
    output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
           red, green, blue, last_of_triangle,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
           red, green, blue, last_of_triangle,
    output ready
  );
endinterface

// ===== sv/fts_ctrl.sv =====
module fts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fts_pkg::fts_stat_t stat_i,
  output fts_pkg::fts_cmd_t  cmd_o
);

  fts_pkg::fts_state_e state_q, state_d;
  logic [2:0]          cnt_q, cnt_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fts_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      fts_pkg::ST_IDLE: begin
        if (stat_i.tri_start) state_d = fts_pkg::ST_DIFF;
      end
      fts_pkg::ST_DIFF: begin
        state_d = fts_pkg::ST_PROD;
        cnt_d   = '0;
      end
      fts_pkg::ST_PROD: begin
        if (cnt_q == fts_pkg::PROD_LAST) begin
          state_d = fts_pkg::ST_CROSS;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      fts_pkg::ST_CROSS:  state_d = fts_pkg::ST_SQINIT;
      fts_pkg::ST_SQINIT: state_d = fts_pkg::ST_SQUARE;
      fts_pkg::ST_SQUARE: begin
        if (stat_i.sq_done) state_d = fts_pkg::ST_SUM;
      end
      fts_pkg::ST_SUM:   state_d = fts_pkg::ST_NINIT;
      fts_pkg::ST_NINIT: state_d = fts_pkg::ST_NORM;
      fts_pkg::ST_NORM: begin
        if (stat_i.norm_done) begin
          state_d = fts_pkg::ST_EMIT;
          cnt_d   = '0;
        end
      end
      fts_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          if (cnt_q == fts_pkg::BEAT_LAST) begin
            state_d = fts_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      default: state_d = fts_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.idx       = cnt_q;
    case (state_q)
      fts_pkg::ST_IDLE:   cmd_o.in_ready  = 1'b1;
      fts_pkg::ST_DIFF:   cmd_o.diff_en   = 1'b1;
      fts_pkg::ST_PROD:   cmd_o.prod_en   = 1'b1;
      fts_pkg::ST_CROSS:  cmd_o.cross_en  = 1'b1;
      fts_pkg::ST_SQINIT: cmd_o.sq_init   = 1'b1;
      fts_pkg::ST_SQUARE: cmd_o.sq_step   = !stat_i.sq_done;
      fts_pkg::ST_SUM:    cmd_o.sum_en    = 1'b1;
      fts_pkg::ST_NINIT:  cmd_o.norm_init = 1'b1;
      fts_pkg::ST_NORM:   cmd_o.norm_step = !stat_i.norm_done;
      fts_pkg::ST_EMIT:   cmd_o.out_load  = stat_i.out_free;
      default:            cmd_o.in_ready  = 1'b0;
    endcase
  end

  // Counter never runs past the six products or six beats
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fts_pkg::ST_PROD || state_q == fts_pkg::ST_EMIT) |-> cnt_q <= 3'd5)
    else $error("step counter out of range");

  // A triangle is not left before its sixth beat is loaded
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fts_pkg::ST_EMIT && cnt_q != fts_pkg::BEAT_LAST) |=>
      state_q == fts_pkg::ST_EMIT)
    else $error("emit left early");

  // Edge set-up always leads into the products
  a_diff_to_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fts_pkg::ST_DIFF |=> state_q == fts_pkg::ST_PROD)
    else $error("products skipped");

endmodule

// ===== sv/fts_datapath.sv =====
module fts_datapath #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fts_pkg::fts_cmd_t  cmd_i,
  output fts_pkg::fts_stat_t stat_o,
  fts_vtx_if.sink            vtx_i,
  fts_tri_if.source          tri_o
);

  localparam int CB  = COORD_BITS;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NB  = F + 2;          // normal output width
  localparam int DW  = CB + 1;         // edge vector width
  localparam int PW2 = 2 * DW;         // partial product width
  localparam int CPW = PW2 + 1;        // cross component width
  localparam int MW  = CPW;            // cross magnitude width
  localparam int SQW = 2 * MW;         // squared component
  localparam int SW  = SQW + 2;        // sum of squares
  localparam int PW  = SW + 2 * F + 5; // signed work width of the root search

  // Polygon state
  logic signed [CB-1:0] origin_q [3];
  logic signed [CB-1:0] prior_q  [3];
  logic signed [CB-1:0] cur_q    [3];
  logic [1:0]           seen_q;
  logic [2:0]           color_q;

  // Edge vectors, products, cross product
  logic signed [DW-1:0]  u_q [3];
  logic signed [DW-1:0]  w_q [3];
  logic signed [PW2-1:0] p_q [6];
  logic signed [CPW-1:0] c_q [3];

  // Shift-add squaring lanes
  logic [SQW-1:0] sa_q   [3];
  logic [MW-1:0]  sb_q   [3];
  logic [SQW-1:0] sacc_q [3];
  logic [SW-1:0]  s_q;
  logic           zero_q;

  // Root search lanes
  logic signed [PW-1:0] pp_q [3];
  logic signed [PW-1:0] qs_q [3];
  logic signed [PW-1:0] tt_q [3];
  logic signed [PW-1:0] ss_q;
  logic [F:0]           bit_q;
  logic [F:0]           m_q [3];

  // Output register
  logic                 ovld_q;
  logic signed [CB-1:0] opos_q [3];
  logic signed [NB-1:0] onrm_q [3];
  logic [23:0]          orgb_q;
  logic                 olast_q;

  logic                 accept;
  logic signed [CB-1:0] vin [3];
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW2-1:0] mul_p;
  logic signed [PW-1:0] trial [3];
  logic signed [CB-1:0] bpos [3];
  logic signed [NB-1:0] bnrm [3];
  logic                 back;

  assign accept = vtx_i.valid && cmd_i.in_ready;
  assign vtx_i.ready = cmd_i.in_ready;
  assign vin[0] = vtx_i.vertex_x;
  assign vin[1] = vtx_i.vertex_y;
  assign vin[2] = vtx_i.vertex_z;

  // Status
  assign stat_o.tri_start = vtx_i.valid && !vtx_i.starts_polygon &&
                            (seen_q == fts_pkg::SEEN_TWO);
  assign stat_o.sq_done   = (sb_q[0] == '0) && (sb_q[1] == '0) && (sb_q[2] == '0);
  assign stat_o.norm_done = (bit_q == '0);
  assign stat_o.out_free  = !ovld_q || tri_o.ready;

  // Polygon bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= fts_pkg::SEEN_NONE;
      color_q <= fts_pkg::COLOR_DEFAULT;
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        prior_q[i]  <= '0;
      end
    end else begin
      if (accept) begin
        if (vtx_i.starts_polygon) begin
          seen_q   <= fts_pkg::SEEN_ORIGIN;
          color_q  <= (vtx_i.color_index > 8'd7) ? fts_pkg::COLOR_DEFAULT
                                                  : vtx_i.color_index[2:0];
          origin_q <= vin;
        end else if (seen_q == fts_pkg::SEEN_ORIGIN) begin
          seen_q  <= fts_pkg::SEEN_TWO;
          prior_q <= vin;
        end
      end
      // current vertex becomes the prior once its triangle is out
      if (cmd_i.out_load && cmd_i.idx == fts_pkg::BEAT_LAST) prior_q <= cur_q;
    end
  end

  // Current vertex
  always_ff @(posedge clk_i) begin
    if (accept && stat_o.tri_start) cur_q <= vin;
  end

  // Edges from the fan origin
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= DW'(prior_q[i]) - DW'(origin_q[i]);
        w_q[i] <= DW'(cur_q[i]) - DW'(origin_q[i]);
      end
    end
  end

  // Shared multiplier, one partial product a cycle
  always_comb begin
    case (cmd_i.idx)
      3'd0:    begin mul_a = u_q[1]; mul_b = w_q[2]; end
      3'd1:    begin mul_a = u_q[2]; mul_b = w_q[1]; end
      3'd2:    begin mul_a = u_q[2]; mul_b = w_q[0]; end
      3'd3:    begin mul_a = u_q[0]; mul_b = w_q[2]; end
      3'd4:    begin mul_a = u_q[0]; mul_b = w_q[1]; end
      default: begin mul_a = u_q[1]; mul_b = w_q[0]; end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) p_q[cmd_i.idx] <= mul_p;
    if (cmd_i.cross_en) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CPW'(p_q[2*i]) - CPW'(p_q[2*i+1]);
      end
    end
  end

  // Squaring lanes, one multiplier bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) sb_q[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (cmd_i.sq_init) begin
          sb_q[i] <= c_q[i][CPW-1] ? MW'(-c_q[i]) : MW'(c_q[i]);
        end else if (cmd_i.sq_step) begin
          sb_q[i] <= sb_q[i] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.sq_init) begin
        sa_q[i]   <= c_q[i][CPW-1] ? SQW'(MW'(-c_q[i])) : SQW'(MW'(c_q[i]));
        sacc_q[i] <= '0;
      end else if (cmd_i.sq_step) begin
        if (sb_q[i][0]) sacc_q[i] <= sacc_q[i] + sa_q[i];
        sa_q[i] <= sa_q[i] << 1;
      end
    end
    if (cmd_i.sum_en) begin
      s_q    <= SW'(sacc_q[0]) + SW'(sacc_q[1]) + SW'(sacc_q[2]);
      zero_q <= (sacc_q[0] == '0) && (sacc_q[1] == '0) && (sacc_q[2] == '0);
    end
  end

  // Root search: largest m with (2m-1)^2 * S <= c^2 * 4^(F+1), one bit a cycle.
  // P holds t^2*S, QS holds t*S aligned to the trial bit, SS holds S aligned.
  always_comb begin
    for (int i = 0; i < 3; i++) trial[i] = pp_q[i] + qs_q[i] + ss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.norm_init) begin
      bit_q <= {1'b1, {F{1'b0}}};
    end else if (cmd_i.norm_step) begin
      bit_q <= bit_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_init) begin
      ss_q <= $signed(PW'(s_q)) <<< (2 * F + 2);
      for (int i = 0; i < 3; i++) begin
        pp_q[i] <= $signed(PW'(s_q));
        qs_q[i] <= -($signed(PW'(s_q)) <<< (F + 2));
        tt_q[i] <= $signed(PW'(sacc_q[i])) <<< (2 * F + 2);
        m_q[i]  <= '0;
      end
    end else if (cmd_i.norm_step) begin
      ss_q <= ss_q >>> 2;
      for (int i = 0; i < 3; i++) begin
        if (trial[i] <= tt_q[i]) begin
          pp_q[i] <= trial[i];
          m_q[i]  <= m_q[i] | bit_q;
          qs_q[i] <= (qs_q[i] >>> 1) + ss_q;
        end else begin
          qs_q[i] <= qs_q[i] >>> 1;
        end
      end
    end
  end

  // Beat assembly
  assign back = (cmd_i.idx >= fts_pkg::BACK_FIRST);

  always_comb begin
    case (cmd_i.idx)
      fts_pkg::BEAT_F_ORIGIN, fts_pkg::BEAT_B_ORIGIN: bpos = origin_q;
      fts_pkg::BEAT_F_PRIOR,  fts_pkg::BEAT_B_PRIOR:  bpos = prior_q;
      fts_pkg::BEAT_F_CUR,    fts_pkg::BEAT_B_CUR:    bpos = cur_q;
      default:                                        bpos = cur_q;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (zero_q) begin
        bnrm[i] = '0;
      end else if (c_q[i][CPW-1] ^ back) begin
        bnrm[i] = -$signed({1'b0, m_q[i]});
      end else begin
        bnrm[i] = $signed({1'b0, m_q[i]});
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovld_q <= 1'b1;
    end else if (tri_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      opos_q  <= bpos;
      onrm_q  <= bnrm;
      orgb_q  <= fts_pkg::palette_rgb(color_q);
      olast_q <= (cmd_i.idx == fts_pkg::BEAT_LAST);
    end
  end

  assign tri_o.valid            = ovld_q;
  assign tri_o.pos_x            = opos_q[0];
  assign tri_o.pos_y            = opos_q[1];
  assign tri_o.pos_z            = opos_q[2];
  assign tri_o.norm_x           = onrm_q[0];
  assign tri_o.norm_y           = onrm_q[1];
  assign tri_o.norm_z           = onrm_q[2];
  assign tri_o.red              = orgb_q[23:16];
  assign tri_o.green            = orgb_q[15:8];
  assign tri_o.blue             = orgb_q[7:0];
  assign tri_o.last_of_triangle = olast_q;

  // Vertex count never takes the unused code
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("vertex count corrupt");

  // Only a free output slot is loaded
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && ovld_q) |-> tri_o.ready)
    else $error("output beat overwritten");

  // A waiting beat stays put until taken
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_o.valid && !tri_o.ready) |=>
      (tri_o.valid && $stable(tri_o.pos_x) && $stable(tri_o.norm_x) &&
       $stable(tri_o.last_of_triangle)))
    else $error("waiting beat changed");

endmodule

// ===== sv/fan_triangulate_double_sided_core.sv =====
// A closing vertex passes through edge set-up, the products, the cross product, the
// bit-serial squaring loop, the sum of squares, the bit-serial root search and the six
// output beats, which wait for the sink; the squaring loop ends early for short cross
// products. No new vertex is accepted until the last beat is loaded; other vertices are
// accepted while the core is idle. Reset clears the open polygon, selects palette entry 7
// and empties the output register; nothing needs a clearing pass.
module fan_triangulate_double_sided_core #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fts_vtx_if.sink   vtx_i,
  fts_tri_if.source tri_o
);

  fts_pkg::fts_cmd_t  cmd;
  fts_pkg::fts_stat_t stat;

  fts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fts_datapath #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .vtx_i  (vtx_i),
    .tri_o  (tri_o)
  );

endmodule
